// ----- design/cas_pkg.sv -----
// Shared types and constants for the cave smoothing pass block.
// Used by cas_cfg and cave_automaton_smoothing_pass_top; no dependencies.
package cas_pkg;

	localparam int MAX_WIDTH_DEF  = 64;
	localparam int MAX_HEIGHT_DEF = 64;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Register indexes (paddr[3:2]).
	localparam logic [1:0] REG_GRID_WIDTH   = 2'd0;
	localparam logic [1:0] REG_GRID_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_THRESHOLD    = 2'd2;
	localparam logic [1:0] REG_COUNT_CENTER = 2'd3;

	localparam logic [6:0] GRID_WIDTH_RST   = 7'd64;
	localparam logic [6:0] GRID_HEIGHT_RST  = 7'd64;
	localparam logic [3:0] THRESHOLD_RST    = 4'd4;
	localparam logic       COUNT_CENTER_RST = 1'b1;

	// Request operation codes.
	localparam logic OP_CELL  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef struct packed {
		logic [6:0] grid_width;
		logic [6:0] grid_height;
		logic [3:0] solid_threshold;
		logic       count_center;
	} cfg_t;

endpackage

// ----- design/cas_cell.sv -----
// One storage cell of a row delay line: shifts from its neighbor or takes
// the new request bit when it is the insertion point. No dependencies.
module cas_cell (
	input  logic clk,
	input  logic shift,
	input  logic load,
	input  logic din_new,
	input  logic din_prev,
	output logic q
);

	logic bit_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			bit_q <= load ? din_new : din_prev;
		end
	end

	assign q = bit_q;

endmodule

// ----- design/cas_line.sv -----
// Row delay line of variable length built from a chain of cas_cell.
// A bit inserted at cell insert_idx reaches the last cell after
// DEPTH - insert_idx shifts. Depends on cas_cell.
module cas_line #(
	parameter int DEPTH = 64,
	parameter int IW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          shift,
	input  logic [IW-1:0] insert_idx,
	input  logic          din,
	output logic          dout
);

	logic [DEPTH-1:0] q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic prev;
		if (i == 0) begin : g_head
			assign prev = 1'b0;
		end else begin : g_body
			assign prev = q[i-1];
		end
		cas_cell u_cell (
			.clk     (clk),
			.shift   (shift),
			.load    (insert_idx == IW'(i)),
			.din_new (din),
			.din_prev(prev),
			.q       (q[i])
		);
	end

	assign dout = q[DEPTH-1];

endmodule

// ----- design/cas_cfg.sv -----
// APB-style configuration registers of the smoothing pass.
// Any write pulses restart so the pass starts over. Depends on cas_pkg.
module cas_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [cas_pkg::ADDR_W-1:0] paddr,
	input  logic [cas_pkg::DATA_W-1:0] pwdata,
	output logic [cas_pkg::DATA_W-1:0] prdata,
	output logic                      pready,
	output cas_pkg::cfg_t             cfg,
	output logic                      restart
);
	import cas_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] idx;

	assign idx   = paddr[3:2];
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width      <= GRID_WIDTH_RST;
			cfg_q.grid_height     <= GRID_HEIGHT_RST;
			cfg_q.solid_threshold <= THRESHOLD_RST;
			cfg_q.count_center    <= COUNT_CENTER_RST;
		end else if (wr_en) begin
			case (idx)
				REG_GRID_WIDTH:   cfg_q.grid_width      <= pwdata[6:0];
				REG_GRID_HEIGHT:  cfg_q.grid_height     <= pwdata[6:0];
				REG_THRESHOLD:    cfg_q.solid_threshold <= pwdata[3:0];
				REG_COUNT_CENTER: cfg_q.count_center    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_GRID_WIDTH:   prdata = DATA_W'(cfg_q.grid_width);
			REG_GRID_HEIGHT:  prdata = DATA_W'(cfg_q.grid_height);
			REG_THRESHOLD:    prdata = DATA_W'(cfg_q.solid_threshold);
			REG_COUNT_CENTER: prdata = DATA_W'(cfg_q.count_center);
			default:          prdata = '0;
		endcase
	end

	assign pready  = 1'b1;
	assign cfg     = cfg_q;
	assign restart = wr_en;

endmodule

// ----- design/cave_automaton_smoothing_pass_top.sv -----
// Top level of the cave smoothing pass: one 3x3 majority-style step over a
// raster-order binary grid. Depends on cas_pkg, cas_cfg, cas_line.
//
// Usage: requests enter on in_valid/in_ready with operation and cell_solid;
// results leave on out_valid/out_ready. Send the grid_width * grid_height
// cells in raster order, then grid_width + 1 flush requests. A flush sent
// before the last cell is accepted and dropped; a cell sent after the last
// cell counts as a flush. The result for cell (r, c) is computed when the
// request at raster index (r + 1) * w + c + 1 is accepted and appears on the
// outputs in the cycle after. One request is accepted per cycle while in_ready
// is high; the rate is set by the registered 3x3 window fed from two row delay
// lines built as chains of single-bit cells. The output register lets a new
// request in while a result is taken; in_ready drops only when a result is held
// and out_ready is low. frame_last marks the final cell and frame_stable tells
// whether the pass left every cell unchanged; the next pass starts then.
// Reset (arst_n low) loads the register defaults and starts a new pass; any
// register write also restarts the pass. Positions are reported modulo 64.
module cave_automaton_smoothing_pass_top #(
	parameter int MAX_WIDTH  = cas_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = cas_pkg::MAX_HEIGHT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [cas_pkg::ADDR_W-1:0] paddr,
	input  logic [cas_pkg::DATA_W-1:0] pwdata,
	output logic [cas_pkg::DATA_W-1:0] prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      operation,
	input  logic                      cell_solid,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      new_solid,
	output logic [5:0]                cell_row,
	output logic [5:0]                cell_column,
	output logic                      frame_last,
	output logic                      frame_stable
);
	import cas_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int LW  = ($clog2(MAX_WIDTH + 1) > 7) ? $clog2(MAX_WIDTH + 1) : 7;
	localparam int LH  = ($clog2(MAX_HEIGHT + 1) > 7) ? $clog2(MAX_HEIGHT + 1) : 7;
	localparam int CWX = (CW > 6) ? CW : 6;
	localparam int RWX = (RW > 6) ? RW : 6;

	cfg_t cfg;
	logic restart;

	cas_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg),
		.restart(restart)
	);

	// Effective grid size, clamped to 1..MAX.
	logic [LW-1:0] gw_ext, w_eff, w_m1;
	logic [LH-1:0] gh_ext, h_eff, h_m1;

	always_comb begin
		gw_ext = LW'(cfg.grid_width);
		gh_ext = LH'(cfg.grid_height);
		if (gw_ext == '0) begin
			w_eff = LW'(1);
		end else if (gw_ext > LW'(MAX_WIDTH)) begin
			w_eff = LW'(MAX_WIDTH);
		end else begin
			w_eff = gw_ext;
		end
		if (gh_ext == '0) begin
			h_eff = LH'(1);
		end else if (gh_ext > LH'(MAX_HEIGHT)) begin
			h_eff = LH'(MAX_HEIGHT);
		end else begin
			h_eff = gh_ext;
		end
		w_m1 = w_eff - LW'(1);
		h_m1 = h_eff - LH'(1);
	end

	// Pass control state.
	logic [CW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] in_row_q, out_row_q;
	logic [LW:0]   lead_q;
	logic          done_q, any_q;

	// Output register.
	logic          out_valid_q, new_solid_q, last_q, stable_q;
	logic [5:0]    row_q, col_q;

	logic acc, is_cell, step, emitting, emit, din;

	assign in_ready = ~out_valid_q | out_ready;
	assign acc      = in_valid & in_ready;
	assign is_cell  = (operation == OP_CELL) & ~done_q;
	assign step     = acc & (is_cell | done_q);
	assign emitting = lead_q >= ((LW + 1)'(w_eff) + (LW + 1)'(1));
	assign emit     = step & emitting;
	assign din      = is_cell & cell_solid;

	// Window taps: p* are the two previous requests, a* the row above that,
	// b* two rows above.
	logic [CW-1:0] insert_idx;
	logic          a0, b0, p1_q, p2_q, a1_q, a2_q, b1_q, b2_q;

	assign insert_idx = CW'(LW'(MAX_WIDTH) - w_eff);

	cas_line #(.DEPTH(MAX_WIDTH), .IW(CW)) u_line_a (
		.clk       (clk),
		.shift     (step),
		.insert_idx(insert_idx),
		.din       (din),
		.dout      (a0)
	);

	cas_line #(.DEPTH(MAX_WIDTH), .IW(CW)) u_line_b (
		.clk       (clk),
		.shift     (step),
		.insert_idx(insert_idx),
		.din       (a0),
		.dout      (b0)
	);

	always_ff @(posedge clk) begin
		if (step) begin
			p1_q <= din;
			p2_q <= p1_q;
			a1_q <= a0;
			a2_q <= a1_q;
			b1_q <= b0;
			b2_q <= b1_q;
		end
	end

	// Rule evaluation for the cell at the output position.
	logic       at_top, at_bot, at_left, at_right;
	logic       n_ul, n_u, n_ur, n_l, n_r, n_dl, n_d, n_dr, center, fresh;
	logic [3:0] count;
	logic       in_last, out_last, changed;

	always_comb begin
		at_top   = out_row_q == '0;
		at_bot   = LH'(out_row_q) == h_m1;
		at_left  = out_col_q == '0;
		at_right = LW'(out_col_q) == w_m1;
		// Positions outside the grid count as solid.
		n_ul   = b2_q | at_top | at_left;
		n_u    = b1_q | at_top;
		n_ur   = b0   | at_top | at_right;
		n_l    = a2_q | at_left;
		center = a1_q;
		n_r    = a0   | at_right;
		n_dl   = p2_q | at_bot | at_left;
		n_d    = p1_q | at_bot;
		n_dr   = din  | at_bot | at_right;
		count  = 4'(n_ul) + 4'(n_u) + 4'(n_ur) + 4'(n_l) + 4'(n_r)
		       + 4'(n_dl) + 4'(n_d) + 4'(n_dr) + 4'(center & cfg.count_center);
		fresh    = count > cfg.solid_threshold;
		changed  = fresh != center;
		out_last = at_bot & at_right;
		in_last  = (LH'(in_row_q) == h_m1) & (LW'(in_col_q) == w_m1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			lead_q    <= '0;
			done_q    <= 1'b0;
			any_q     <= 1'b0;
		end else if (restart || (emit && out_last)) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			lead_q    <= '0;
			done_q    <= 1'b0;
			any_q     <= 1'b0;
		end else if (step) begin
			if (!emitting) begin
				lead_q <= lead_q + (LW + 1)'(1);
			end
			if (is_cell) begin
				if (in_last) begin
					done_q <= 1'b1;
				end else if (LW'(in_col_q) == w_m1) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + RW'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end
			if (emit) begin
				any_q <= any_q | changed;
				if (at_right) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + RW'(1);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	logic [RWX-1:0] row_ext;
	logic [CWX-1:0] col_ext;

	assign row_ext = RWX'(out_row_q);
	assign col_ext = CWX'(out_col_q);

	always_ff @(posedge clk) begin
		if (emit) begin
			new_solid_q <= fresh;
			row_q       <= row_ext[5:0];
			col_q       <= col_ext[5:0];
			last_q      <= out_last;
			stable_q    <= out_last & ~(any_q | changed);
		end
	end

	assign out_valid    = out_valid_q;
	assign new_solid    = new_solid_q;
	assign cell_row     = row_q;
	assign cell_column  = col_q;
	assign frame_last   = last_q;
	assign frame_stable = stable_q;

endmodule
